// ===== sv/lfr_pkg.sv =====
// shared types and constants of the line filter with reflected or valid edges
`timescale 1ns / 1ps
package lfr_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int PROD_W    = 2 * SAMPLE_W;
	localparam int FRAC_BITS = 14;
	localparam int NUM_COEF  = 5;
	localparam int POS_W     = 3;
	localparam int CFG_IDX_W = 3;
	localparam int SAT_MAX   = 32767;
	localparam int SAT_MIN   = -32768;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_COEF_0    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_2    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE = 3'd5;

	// reset value of the centre tap, 1.0 in Q1.14
	localparam logic signed [SAMPLE_W-1:0] COEF_CENTRE_RST = 16'sd16384;

	// rounding constant, one half in Q1.14
	localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic {
		EDGE_SAME  = 1'b0,
		EDGE_VALID = 1'b1
	} edge_mode_t;

	// flags that travel with each result word
	typedef struct packed {
		logic last_of_line;
		logic short_line;
	} meta_t;

endpackage

// ===== sv/lfr_front.sv =====
// sample window, line position and result sequencer feeding the tap chain
`timescale 1ns / 1ps
module lfr_front #(
	parameter int KERN_LEN = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lfr_pkg::edge_mode_t edge_mode,
	input  logic                in_valid,
	output logic                in_stall,
	input  lfr_pkg::sample_t    sample,
	input  logic                end_of_line,
	input  logic                cell_ready,
	output logic                fe_valid,
	output lfr_pkg::sample_t    fe_win [KERN_LEN],
	output lfr_pkg::meta_t      fe_meta
);
	import lfr_pkg::*;

	localparam int HALF    = KERN_LEN / 2;
	localparam int WIN_LEN = KERN_LEN - 1;
	localparam int IDX_W   = $clog2(KERN_LEN);
	localparam int D_W     = $clog2(HALF + 1);
	localparam logic [POS_W-1:0] HALF_POS = POS_W'(HALF);
	localparam logic [POS_W-1:0] FULL_POS = POS_W'(KERN_LEN - 1);
	localparam logic [POS_W-1:0] POS_MAX  = '1;
	localparam logic [D_W-1:0]   D_LAST   = D_W'(HALF);
	localparam logic [D_W-1:0]   D_FIRST  = D_W'(1);

	sample_t          win_q [WIN_LEN];
	logic [POS_W-1:0] pos_q;
	logic             busy_q;
	sample_t          hist_q [KERN_LEN];
	logic [POS_W-1:0] n_q;
	logic [D_W-1:0]   d_q;

	logic             fe_valid_q;
	sample_t          fe_win_q [KERN_LEN];
	meta_t            fe_meta_q;

	sample_t          hist [KERN_LEN];
	sample_t          sel_hist [KERN_LEN];
	logic [POS_W-1:0] sel_n;
	logic [D_W-1:0]   sel_d;
	logic             fe_adv;
	logic             acc;
	logic             start_multi;
	logic             iss_go;
	logic             iss_short;
	logic             iss_last;
	logic             iss_reflect;
	sample_t          iss_win [KERN_LEN];

	// window offset of tap k for the same-mode result d places after the oldest centre
	function automatic int same_off(int n, int d, int k);
		int r;
		int p;
		r = d + k - 2 * HALF;
		p = n + r;
		priority if (r > 0) begin
			return r - 1;
		end else if (p < 0) begin
			return 2 * n + r;
		end else begin
			return -r;
		end
	endfunction

	// current sample plus the stored history, newest first
	always_comb begin
		hist[0] = sample;
		for (int j = 1; j < KERN_LEN; j++) begin
			hist[j] = win_q[j-1];
		end
	end

	// handshake
	assign fe_adv      = !fe_valid_q || cell_ready;
	assign in_stall    = busy_q || !fe_adv;
	assign acc         = in_valid && !in_stall;
	assign start_multi = (edge_mode == EDGE_SAME) && end_of_line && (pos_q >= HALF_POS);

	// source of the word to issue: the live window or the saved end-of-line window
	always_comb begin
		for (int k = 0; k < KERN_LEN; k++) begin
			sel_hist[k] = busy_q ? hist_q[k] : hist[k];
		end
		sel_n = busy_q ? n_q : pos_q;
		sel_d = busy_q ? d_q : '0;
	end

	// decide what the current cycle issues
	always_comb begin
		iss_go      = 1'b0;
		iss_short   = 1'b0;
		iss_last    = 1'b0;
		iss_reflect = 1'b0;
		if (busy_q) begin
			iss_go      = fe_adv;
			iss_reflect = 1'b1;
			iss_last    = (d_q == D_LAST);
		end else if (acc) begin
			if (edge_mode == EDGE_SAME) begin
				if (end_of_line) begin
					iss_go = 1'b1;
					if (pos_q < HALF_POS) begin
						iss_short = 1'b1;
						iss_last  = 1'b1;
					end else begin
						iss_reflect = 1'b1;
					end
				end else if (pos_q >= HALF_POS) begin
					iss_go      = 1'b1;
					iss_reflect = 1'b1;
				end
			end else begin
				if (pos_q >= FULL_POS) begin
					iss_go   = 1'b1;
					iss_last = end_of_line;
				end else if (end_of_line) begin
					iss_go    = 1'b1;
					iss_short = 1'b1;
					iss_last  = 1'b1;
				end
			end
		end
	end

	// tap inputs of the issued word, mirrored at the edges in same mode, all zero for a short line
	always_comb begin
		for (int k = 0; k < KERN_LEN; k++) begin
			if (iss_short) begin
				iss_win[k] = '0;
			end else if (iss_reflect) begin
				iss_win[k] = sel_hist[IDX_W'(same_off(int'(sel_n), int'(sel_d), k))];
			end else begin
				iss_win[k] = hist[KERN_LEN-1-k];
			end
		end
	end

	// issue register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_valid_q <= 1'b0;
		end else if (fe_adv) begin
			fe_valid_q <= iss_go;
		end
	end

	always_ff @(posedge clk) begin
		if (fe_adv) begin
			fe_win_q                <= iss_win;
			fe_meta_q.last_of_line  <= iss_last;
			fe_meta_q.short_line    <= iss_short;
		end
	end

	// end-of-line sequencer for the trailing same-mode words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			d_q    <= '0;
			n_q    <= '0;
		end else if (busy_q) begin
			if (fe_adv) begin
				if (d_q == D_LAST) begin
					busy_q <= 1'b0;
				end else begin
					d_q <= d_q + D_FIRST;
				end
			end
		end else if (acc && start_multi) begin
			busy_q <= 1'b1;
			d_q    <= D_FIRST;
			n_q    <= pos_q;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && acc && start_multi) begin
			hist_q <= hist;
		end
	end

	// sample window and line position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			for (int j = 0; j < WIN_LEN; j++) begin
				win_q[j] <= '0;
			end
		end else if (acc) begin
			if (end_of_line) begin
				pos_q <= '0;
				for (int j = 0; j < WIN_LEN; j++) begin
					win_q[j] <= '0;
				end
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + POS_W'(1);
				end
				win_q[0] <= sample;
				for (int j = 1; j < WIN_LEN; j++) begin
					win_q[j] <= win_q[j-1];
				end
			end
		end
	end

	assign fe_valid = fe_valid_q;
	assign fe_win   = fe_win_q;
	assign fe_meta  = fe_meta_q;

`ifndef SYNTHESIS
	// a line end always restarts the position count
	a_eol_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && end_of_line) |=> (pos_q == '0))
		else $error("line position not cleared after end of line");

	// the sequencer leaves busy right after issuing the last trailing word
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && fe_adv && (d_q == D_LAST)) |=> !busy_q)
		else $error("sequencer stayed busy after the last word");

	// a short-line word is always the final word of its line
	a_short_last: assert property (@(posedge clk) disable iff (!arst_n)
		(fe_valid_q && fe_meta_q.short_line) |-> fe_meta_q.last_of_line)
		else $error("short-line word without last flag");
`endif

endmodule

// ===== sv/lfr_tap_cell.sv =====
// one tap cell: multiplies its tap and adds the neighbor's product into the running sum
`timescale 1ns / 1ps
module lfr_tap_cell #(
	parameter int KERN_LEN = 5,
	parameter int TAP      = 0,
	parameter int ACC_W    = 35
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lfr_pkg::sample_t             coef,
	input  logic                         down_ready,
	output logic                         up_ready,
	input  logic                         in_valid,
	input  lfr_pkg::sample_t             in_win [KERN_LEN],
	input  lfr_pkg::meta_t               in_meta,
	input  logic signed [ACC_W-1:0]      in_sum,
	input  logic signed [lfr_pkg::PROD_W-1:0] in_prod,
	output logic                         out_valid,
	output lfr_pkg::sample_t             out_win [KERN_LEN],
	output lfr_pkg::meta_t               out_meta,
	output logic signed [ACC_W-1:0]      out_sum,
	output logic signed [lfr_pkg::PROD_W-1:0] out_prod
);
	import lfr_pkg::*;

	logic                     valid_q;
	sample_t                  win_q [KERN_LEN];
	meta_t                    meta_q;
	logic signed [ACC_W-1:0]  sum_q;
	logic signed [PROD_W-1:0] prod_q;

	// the cell moves on when it is empty or its neighbor takes the word
	assign up_ready = !valid_q || down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= in_valid;
		end
	end

	// previous tap's product joins the sum, this tap's product is registered
	always_ff @(posedge clk) begin
		if (up_ready) begin
			win_q  <= in_win;
			meta_q <= in_meta;
			sum_q  <= in_sum + ACC_W'(in_prod);
			prod_q <= coef * in_win[TAP];
		end
	end

	assign out_valid = valid_q;
	assign out_win   = win_q;
	assign out_meta  = meta_q;
	assign out_sum   = sum_q;
	assign out_prod  = prod_q;

endmodule

// ===== sv/lfr_out_stage.sv =====
// final add, rounding, saturation and output register
`timescale 1ns / 1ps
module lfr_out_stage #(
	parameter int ACC_W = 35
) (
	input  logic                              clk,
	input  logic                              arst_n,
	output logic                              up_ready,
	input  logic                              in_valid,
	input  lfr_pkg::meta_t                    in_meta,
	input  logic signed [ACC_W-1:0]           in_sum,
	input  logic signed [lfr_pkg::PROD_W-1:0] in_prod,
	output logic                              out_valid,
	input  logic                              out_stall,
	output lfr_pkg::sample_t                  filtered,
	output logic                              last_of_line,
	output logic                              short_line
);
	import lfr_pkg::*;

	localparam int RND_W = ACC_W - FRAC_BITS;

	logic                    valid_q;
	sample_t                 filt_q;
	meta_t                   meta_q;
	logic signed [ACC_W-1:0] total;
	logic signed [RND_W-1:0] rounded;
	sample_t                 sat;

	assign up_ready = !valid_q || !out_stall;

	// round to nearest, ties up, then clamp to 16 bits
	assign total   = in_sum + ACC_W'(in_prod) + ACC_W'(ROUND_HALF);
	assign rounded = RND_W'(total >>> FRAC_BITS);

	always_comb begin
		priority if (rounded > RND_W'(SAT_MAX)) begin
			sat = SAMPLE_W'(SAT_MAX);
		end else if (rounded < RND_W'(SAT_MIN)) begin
			sat = SAMPLE_W'(SAT_MIN);
		end else begin
			sat = rounded[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready) begin
			filt_q <= sat;
			meta_q <= in_meta;
		end
	end

	assign out_valid    = valid_q;
	assign filtered     = filt_q;
	assign last_of_line = meta_q.last_of_line;
	assign short_line   = meta_q.short_line;

`ifndef SYNTHESIS
	// a short line carries an all-zero window, so its word must be zero
	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && meta_q.short_line) |-> (filt_q == '0))
		else $error("short-line word with nonzero value");
`endif

endmodule

// ===== sv/line_fir_reflect_or_valid.sv =====
// top level: config registers, front end, chain of tap cells and output stage
// A result word passes the front issue register, the tap cells and the output register in order.
// Throughput: one sample per cycle unless stalled; a same-mode end of line that is not short issues
// KERN_LEN/2 + 1 words, one per cycle from the front sequencer unless stalled, and holds input meanwhile.
// The tap chain has one cell per tap; a stalled output backs up only as far as the chain is full.
// Reset (asynchronous, active low) empties the chain, clears window and position, loads
// the coefficient and edge mode defaults.
`timescale 1ns / 1ps
module line_fir_reflect_or_valid #(
	parameter int KERN_LEN = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lfr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lfr_pkg::SAMPLE_W-1:0]        cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  lfr_pkg::sample_t                    sample,
	input  logic                                end_of_line,
	output logic                                out_valid,
	input  logic                                out_stall,
	output lfr_pkg::sample_t                    filtered,
	output logic                                last_of_line,
	output logic                                short_line
);
	import lfr_pkg::*;

	localparam int ACC_W = PROD_W + $clog2(KERN_LEN);

	sample_t    coef_q [NUM_COEF];
	edge_mode_t edge_mode_q;

	logic       fe_valid;
	sample_t    fe_win [KERN_LEN];
	meta_t      fe_meta;

	logic                     c_ready [KERN_LEN];
	logic                     c_valid [KERN_LEN];
	sample_t                  c_win   [KERN_LEN][KERN_LEN];
	meta_t                    c_meta  [KERN_LEN];
	logic signed [ACC_W-1:0]  c_sum   [KERN_LEN];
	logic signed [PROD_W-1:0] c_prod  [KERN_LEN];
	sample_t                  c_coef  [KERN_LEN];
	logic                     os_ready;

	// configuration registers, writes beyond the edge mode are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEF; i++) begin
				coef_q[i] <= (i == int'(REG_COEF_2)) ? COEF_CENTRE_RST : '0;
			end
			edge_mode_q <= EDGE_SAME;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_EDGE_MODE) begin
				edge_mode_q <= edge_mode_t'(cfg_data[0]);
			end else if (cfg_index < REG_EDGE_MODE) begin
				coef_q[cfg_index] <= cfg_data;
			end
		end
	end

	lfr_front #(
		.KERN_LEN (KERN_LEN)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.edge_mode   (edge_mode_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.end_of_line (end_of_line),
		.cell_ready  (c_ready[0]),
		.fe_valid    (fe_valid),
		.fe_win      (fe_win),
		.fe_meta     (fe_meta)
	);

	// row of tap cells, taps past the register set are zero
	for (genvar k = 0; k < KERN_LEN; k++) begin : g_cell
		logic down_ready;

		if (k < NUM_COEF) begin : g_coef
			assign c_coef[k] = coef_q[k];
		end else begin : g_zero
			assign c_coef[k] = '0;
		end

		if (k == KERN_LEN - 1) begin : g_tail
			assign down_ready = os_ready;
		end else begin : g_mid
			assign down_ready = c_ready[k+1];
		end

		if (k == 0) begin : g_head
			lfr_tap_cell #(
				.KERN_LEN (KERN_LEN),
				.TAP      (k),
				.ACC_W    (ACC_W)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.coef       (c_coef[k]),
				.down_ready (down_ready),
				.up_ready   (c_ready[k]),
				.in_valid   (fe_valid),
				.in_win     (fe_win),
				.in_meta    (fe_meta),
				.in_sum     ('0),
				.in_prod    ('0),
				.out_valid  (c_valid[k]),
				.out_win    (c_win[k]),
				.out_meta   (c_meta[k]),
				.out_sum    (c_sum[k]),
				.out_prod   (c_prod[k])
			);
		end else begin : g_body
			lfr_tap_cell #(
				.KERN_LEN (KERN_LEN),
				.TAP      (k),
				.ACC_W    (ACC_W)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.coef       (c_coef[k]),
				.down_ready (down_ready),
				.up_ready   (c_ready[k]),
				.in_valid   (c_valid[k-1]),
				.in_win     (c_win[k-1]),
				.in_meta    (c_meta[k-1]),
				.in_sum     (c_sum[k-1]),
				.in_prod    (c_prod[k-1]),
				.out_valid  (c_valid[k]),
				.out_win    (c_win[k]),
				.out_meta   (c_meta[k]),
				.out_sum    (c_sum[k]),
				.out_prod   (c_prod[k])
			);
		end
	end

	lfr_out_stage #(
		.ACC_W (ACC_W)
	) u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_ready     (os_ready),
		.in_valid     (c_valid[KERN_LEN-1]),
		.in_meta      (c_meta[KERN_LEN-1]),
		.in_sum       (c_sum[KERN_LEN-1]),
		.in_prod      (c_prod[KERN_LEN-1]),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.filtered     (filtered),
		.last_of_line (last_of_line),
		.short_line   (short_line)
	);

endmodule

// ===== bench/line_fir_reflect_or_valid_test.sv =====
// testbench for the line filter: directed edge and rounding cases, then random lines and kernels
`timescale 1ns / 1ps
module line_fir_reflect_or_valid_test;
	import lfr_pkg::*;

	localparam int KERN_LEN      = 5;
	localparam int HALF_TAPS     = KERN_LEN / 2;
	localparam int ITEM_TARGET   = 220;
	localparam int SETTLE_CYCLES = KERN_LEN + 10;
	localparam int IDLE_LIMIT    = 2000;
	localparam int MAX_PRINTED   = 60;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_EDGE_MODE + 3'd1;

	typedef struct packed {
		sample_t value;
		logic    eol;
	} line_item_t;

	typedef struct {
		sample_t value;
		logic    last_flag;
		logic    short_flag;
	} word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SAMPLE_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	sample_t sample = '0;
	logic end_of_line = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	sample_t filtered;
	logic last_of_line;
	logic short_line;

	// handshakes seen at the last rising edge
	logic in_fire = 1'b0;
	logic out_fire = 1'b0;
	logic cfg_fire = 1'b0;

	line_item_t pending_samples[$];
	word_t expected_words[$];

	// filter state mirrored by the predictor
	sample_t tap_reg[NUM_COEF] = '{16'sd0, 16'sd0, COEF_CENTRE_RST, 16'sd0, 16'sd0};
	edge_mode_t mode = EDGE_SAME;
	sample_t line_window[KERN_LEN-1] = '{default: '0};
	logic [POS_W-1:0] line_pos = '0;
	sample_t recent[KERN_LEN];

	sample_t kernel_next[NUM_COEF];
	bit input_calm = 1'b0;
	bit output_calm = 1'b0;
	int in_gap = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	int error_count = 0;
	int items_queued = 0;
	int lines_done = 0;
	int words_seen = 0;
	int short_seen = 0;
	int cfg_writes = 0;
	line_item_t next_word;
	word_t want;

	line_fir_reflect_or_valid #(
		.KERN_LEN(KERN_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.end_of_line(end_of_line),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.filtered(filtered),
		.last_of_line(last_of_line),
		.short_line(short_line)
	);

	always #2 clk = ~clk;

	task automatic flag_error(input string msg);
		if (error_count < MAX_PRINTED) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
		error_count++;
	endtask

	function automatic int draw_wait(input bit calm);
		return calm ? 0 : int'($urandom_range(0, 19));
	endfunction

	function automatic sample_t tap_at(input int k);
		return (k < NUM_COEF) ? tap_reg[k] : sample_t'(0);
	endfunction

	// round half up in Q1.14, then clamp to the sample range
	function automatic sample_t round_sat(input longint acc);
		longint q;
		q = (acc + ROUND_HALF) >>> FRAC_BITS;
		if (q > SAT_MAX) q = SAT_MAX;
		else if (q < SAT_MIN) q = SAT_MIN;
		return sample_t'(q);
	endfunction

	// same-size word centred `centre` samples behind the newest one (centre <= 0)
	function automatic sample_t same_word(input int n, input int centre);
		longint acc;
		int k, rel, off;
		acc = 0;
		for (k = 0; k < KERN_LEN; k++) begin
			rel = centre - HALF_TAPS + k;
			// past the newest sample: mirror with the edge repeated
			if (rel > 0) off = rel - 1;
			// before the line start: mirror without repeating the first sample
			else if (n + rel < 0) off = 2 * n + rel;
			else off = -rel;
			if (off >= 0 && off < KERN_LEN) acc += longint'(tap_at(k)) * longint'(recent[off]);
		end
		return round_sat(acc);
	endfunction

	task automatic queue_result(input sample_t v, input logic last, input logic shrt);
		word_t w;
		w.value = v;
		w.last_flag = last;
		w.short_flag = shrt;
		expected_words.push_back(w);
	endtask

	// expected words caused by one accepted sample, then the state update
	task automatic predict_sample(input sample_t s, input logic eol);
		int n, c, j, k;
		longint acc;
		recent[0] = s;
		for (j = 1; j < KERN_LEN; j++) recent[j] = line_window[j-1];
		n = int'(line_pos);
		if (mode == EDGE_SAME) begin
			if (eol) begin
				if (n < HALF_TAPS) queue_result('0, 1'b1, 1'b1);
				else for (c = -HALF_TAPS; c <= 0; c++) queue_result(same_word(n, c), c == 0, 1'b0);
			end else if (n >= HALF_TAPS) begin
				queue_result(same_word(n, -HALF_TAPS), 1'b0, 1'b0);
			end
		end else begin
			if (n >= KERN_LEN - 1) begin
				acc = 0;
				for (k = 0; k < KERN_LEN; k++)
					acc += longint'(tap_at(k)) * longint'(recent[KERN_LEN-1-k]);
				queue_result(round_sat(acc), eol, 1'b0);
			end else if (eol) begin
				queue_result('0, 1'b1, 1'b1);
			end
		end
		if (eol) begin
			line_window = '{default: '0};
			line_pos = '0;
		end else begin
			for (j = KERN_LEN - 2; j > 0; j--) line_window[j] = line_window[j-1];
			line_window[0] = s;
			if (line_pos != '1) line_pos++;
		end
	endtask

	// handshakes, predictor, checker and watchdog at the rising edge
	always @(posedge clk) begin
		in_fire = (in_valid === 1'b1) && (in_stall === 1'b0);
		out_fire = (out_valid === 1'b1) && (out_stall === 1'b0);
		cfg_fire = (cfg_valid === 1'b1) && (cfg_ready === 1'b1);
		if (cfg_fire) begin
			cfg_writes++;
			if (cfg_index < NUM_COEF) tap_reg[cfg_index] = sample_t'(cfg_data);
			else if (cfg_index == REG_EDGE_MODE) mode = edge_mode_t'(cfg_data[0]);
		end
		if (in_fire) begin
			predict_sample(sample, end_of_line);
			if (end_of_line) lines_done++;
		end
		if (out_fire) begin
			words_seen++;
			if (short_line === 1'b1) short_seen++;
			if (expected_words.size() == 0) begin
				flag_error($sformatf("unexpected word filtered=%0d last=%b short=%b",
					filtered, last_of_line, short_line));
			end else begin
				want = expected_words.pop_front();
				if (filtered !== want.value)
					flag_error($sformatf("filtered %0d, want %0d", filtered, want.value));
				if (last_of_line !== want.last_flag)
					flag_error($sformatf("last_of_line %b, want %b", last_of_line, want.last_flag));
				if (short_line !== want.short_flag)
					flag_error($sformatf("short_line %b, want %b", short_line, want.short_flag));
			end
		end
		if (!arst_n || in_fire || out_fire || cfg_fire) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d words outstanding",
				idle_cycles, expected_words.size());
			$display("** line_fir_reflect_or_valid: FAILED **");
			$finish;
		end
	end

	// sample driver: next word after a random gap, held while stalled
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (pending_samples.size() != 0) begin
				next_word = pending_samples.pop_front();
				sample <= next_word.value;
				end_of_line <= next_word.eol;
				in_valid <= 1'b1;
				in_gap = draw_wait(input_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side: random stall after each word taken
	always @(negedge clk) begin
		if (out_fire) stall_left = draw_wait(output_calm);
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_fire);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_kernel(input edge_mode_t m);
		int k;
		for (k = 0; k < NUM_COEF; k++)
			write_reg(CFG_IDX_W'(int'(REG_COEF_0) + k), kernel_next[k]);
		write_reg(REG_EDGE_MODE, SAMPLE_W'(m));
	endtask

	// wait until every word is back and the pipe has run empty
	task automatic settle();
		do @(negedge clk);
		while (pending_samples.size() != 0 || in_valid || expected_words.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic queue_word(input sample_t v, input logic eol);
		line_item_t it;
		it.value = v;
		it.eol = eol;
		pending_samples.push_back(it);
		items_queued++;
	endtask

	function automatic sample_t draw_sample();
		case ($urandom_range(0, 5))
			0: return sample_t'(SAT_MAX);
			1: return sample_t'(SAT_MIN);
			2, 3: return sample_t'($urandom_range(0, 1000) - 500);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic int pick_len();
		case ($urandom_range(0, 9))
			0, 1: return $urandom_range(1, 4);
			8: return $urandom_range(13, 24);
			default: return $urandom_range(5, 12);
		endcase
	endfunction

	task automatic queue_line(input int len, input bit close);
		int i;
		for (i = 0; i < len; i++) queue_word(draw_sample(), close && (i == len - 1));
	endtask

	task automatic pick_kernel();
		int k, sum, style;
		style = $urandom_range(0, 2);
		sum = 0;
		for (k = 0; k < NUM_COEF; k++) begin
			case (style)
				0: kernel_next[k] = sample_t'($urandom);
				1: begin
					kernel_next[k] = sample_t'($urandom_range(0, 4096));
					if (k != int'(REG_COEF_2)) sum += int'(kernel_next[k]);
				end
				default: begin
					case ($urandom_range(0, 3))
						0: kernel_next[k] = sample_t'(SAT_MAX);
						1: kernel_next[k] = sample_t'(SAT_MIN);
						2: kernel_next[k] = '0;
						default: kernel_next[k] = COEF_CENTRE_RST;
					endcase
				end
			endcase
		end
		// smoothing kernel whose taps add up to one
		if (style == 1) kernel_next[REG_COEF_2] = sample_t'(int'(COEF_CENTRE_RST) - sum);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset kernel passes samples through: two short lines, then three samples
		queue_word(sample_t'(SAT_MAX), 1'b1);
		queue_word(sample_t'(SAT_MIN), 1'b0);
		queue_word(sample_t'(1), 1'b1);
		queue_word(sample_t'(SAT_MAX), 1'b0);
		queue_word(sample_t'(SAT_MIN), 1'b0);
		queue_word(sample_t'(-1), 1'b1);
		settle();

		// extreme taps drive the sums past both ends of the output range
		kernel_next = '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767};
		load_kernel(EDGE_SAME);
		queue_word(sample_t'(SAT_MAX), 1'b0);
		queue_word(sample_t'(SAT_MIN), 1'b0);
		queue_word(sample_t'(SAT_MAX), 1'b0);
		queue_word(sample_t'(SAT_MIN), 1'b1);
		settle();

		// half-weight centre tap puts results on rounding ties of both signs
		kernel_next = '{16'sd0, 16'sd0, 16'sd8192, 16'sd0, 16'sd0};
		load_kernel(EDGE_SAME);
		queue_word(sample_t'(1), 1'b0);
		queue_word(sample_t'(-1), 1'b0);
		queue_word(sample_t'(3), 1'b1);
		settle();

		// valid positions only: a line one short of the kernel, then exactly one window
		kernel_next = '{16'sd4096, -16'sd2048, 16'sd12288, 16'sd1024, -16'sd3000};
		load_kernel(EDGE_VALID);
		queue_line(KERN_LEN - 1, 1'b1);
		queue_line(KERN_LEN, 1'b1);
		settle();

		// edge mode switched in the middle of a line
		queue_line(2, 1'b0);
		settle();
		write_reg(REG_EDGE_MODE, SAMPLE_W'(EDGE_SAME));
		queue_line(1, 1'b1);
		settle();

		// random phases: kernels, modes, idling and line lengths change between them
		while (items_queued < ITEM_TARGET) begin
			if ($urandom_range(0, 3) == 0) begin
				write_reg(REG_EDGE_MODE, SAMPLE_W'($urandom));
			end else begin
				pick_kernel();
				load_kernel(edge_mode_t'($urandom_range(0, 1)));
			end
			// indexes past the edge mode register are ignored
			if ($urandom_range(0, 4) == 0)
				write_reg(REG_SPARE + CFG_IDX_W'($urandom_range(0, 1)), SAMPLE_W'($urandom));
			input_calm = ($urandom_range(0, 3) == 0);
			output_calm = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 4)) queue_line(pick_len(), 1'b1);
			// sometimes leave a line open across the next register change
			if ($urandom_range(0, 3) == 0) queue_line($urandom_range(1, 6), 1'b0);
			settle();
		end

		$display("run covered %0d samples in %0d closed lines, %0d result words (%0d short)",
			items_queued, lines_done, words_seen, short_seen);
		$display("%0d register writes, %0d mismatches", cfg_writes, error_count);
		if (error_count == 0) begin
			$display("** line_fir_reflect_or_valid: PASSED **");
		end else begin
			$display("** line_fir_reflect_or_valid: FAILED **");
		end
		$finish;
	end

endmodule
